FILE: sv/montgomery_modular_alu_defines.svh
// Assertion macros shared by the modular ALU.
`ifndef MONTGOMERY_MODULAR_ALU_DEFINES_SVH
`define MONTGOMERY_MODULAR_ALU_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge out of reset.
`define MMA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MMA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mma_pkg.sv
// Types and constants of the modular ALU.
`timescale 1ns / 1ps

package mma_pkg;

    localparam int DATA_W     = 64;
    localparam int RES_W      = 62;
    localparam int CMD_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int MOD_BITS_DEF = 62;

    localparam logic [DATA_W-1:0] MODULUS_RST   = 64'd998244353;
    localparam logic [DATA_W-1:0] R_SQUARED_RST = 64'd299560064;
    localparam logic [DATA_W-1:0] MOD_INV_RST   = 64'd996491785301655553;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODULUS   = 2'd0,
        REG_R_SQUARED = 2'd1,
        REG_MOD_INV   = 2'd2
    } cfg_reg_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_POW = 3'd4,
        CMD_INV = 3'd5,
        CMD_NEG = 3'd6,
        CMD_EQ  = 3'd7
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TM_DIV,
        ST_MM1,
        ST_MM2,
        ST_MM3,
        ST_A_DONE,
        ST_B_DONE,
        ST_R_MM,
        ST_PL_FIN,
        ST_DIV_INV,
        ST_INV_P,
        ST_INV_MOD,
        ST_EU_LOOP,
        ST_EU_DIV,
        ST_EU_MUL,
        ST_POW_INIT,
        ST_POW_LOOP,
        ST_POW_RES,
        ST_POW_SQ,
        ST_POW_BASE,
        ST_NEG_Z,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

FILE: sv/mma_if.sv
// Request and response channel interfaces of the modular ALU.
`timescale 1ns / 1ps

interface mma_req_if;
    logic                              valid;
    logic                              ready;
    logic [mma_pkg::CMD_W-1:0]         command;
    logic signed [mma_pkg::DATA_W-1:0] operand_a;
    logic signed [mma_pkg::DATA_W-1:0] operand_b;

    modport source (output valid, command, operand_a, operand_b, input ready);
    modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

interface mma_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [mma_pkg::RES_W-1:0]  residue;
    logic                       is_equal;

    modport source (output valid, residue, is_equal, input ready);
    modport sink   (input valid, residue, is_equal, output ready);
endinterface

FILE: sv/mma_mul.sv
// Bit-serial 64 x 64 multiplier with full 128-bit product.
`timescale 1ns / 1ps

module mma_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mma_pkg::DATA_W-1:0] a,
    input  logic [mma_pkg::DATA_W-1:0] b,
    output logic [mma_pkg::DATA_W-1:0] hi,
    output logic [mma_pkg::DATA_W-1:0] lo,
    output mma_pkg::unit_stat_t        stat
);

    localparam int CNT_W = $clog2(mma_pkg::DATA_W);

    logic                       busy_reg;
    logic                       done_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [mma_pkg::DATA_W-1:0] mcand_reg;
    logic [mma_pkg::DATA_W-1:0] hi_reg;
    logic [mma_pkg::DATA_W-1:0] lo_reg;
    logic [mma_pkg::DATA_W:0]   sum;
    logic                       load;

    assign load = start && !busy_reg && !done_reg;
    // multiplier sits in lo and shifts out as the product shifts in
    assign sum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(mma_pkg::DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mcand_reg <= a;
            hi_reg    <= '0;
            lo_reg    <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[mma_pkg::DATA_W:1];
            lo_reg <= {sum[0], lo_reg[mma_pkg::DATA_W-1:1]};
        end
    end

    assign hi        = hi_reg;
    assign lo        = lo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: sv/mma_div.sv
// Bit-serial restoring 64-bit unsigned divider.
`timescale 1ns / 1ps

module mma_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mma_pkg::DATA_W-1:0] dividend,
    input  logic [mma_pkg::DATA_W-1:0] divisor,
    output logic [mma_pkg::DATA_W-1:0] quotient,
    output logic [mma_pkg::DATA_W-1:0] remainder,
    output mma_pkg::unit_stat_t        stat
);

    localparam int CNT_W = $clog2(mma_pkg::DATA_W);

    logic                       busy_reg;
    logic                       done_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [mma_pkg::DATA_W-1:0] dvs_reg;
    logic [mma_pkg::DATA_W-1:0] rem_reg;
    logic [mma_pkg::DATA_W-1:0] quo_reg;
    logic [mma_pkg::DATA_W:0]   trial;
    logic [mma_pkg::DATA_W:0]   diff;
    logic                       load;

    assign load  = start && !busy_reg && !done_reg;
    assign trial = {rem_reg, quo_reg[mma_pkg::DATA_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(mma_pkg::DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            // keep the trial remainder when the divisor does not fit
            if (!diff[mma_pkg::DATA_W])
            begin
                rem_reg <= diff[mma_pkg::DATA_W-1:0];
                quo_reg <= {quo_reg[mma_pkg::DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[mma_pkg::DATA_W-1:0];
                quo_reg <= {quo_reg[mma_pkg::DATA_W-2:0], 1'b0};
            end
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: sv/montgomery_modular_alu.sv
// Montgomery modular ALU top level: sequencer, operand registers and config.
//
// req carries command, operand_a and operand_b; rsp returns residue and
// is_equal, one beat per request beat, in order. The cfg port writes the
// modulus, R^2 mod m and m^-1 mod 2^64 by index; write only while idle.
// Work runs on one bit-serial multiplier and one bit-serial divider; a
// Montgomery product costs three multiplier passes. Converting each
// operand costs one divide and one product. Equal then compares directly;
// add and sub cost one more product and mul two more, while negate also
// converts a zero and then costs one more product. Power adds up to two
// products per exponent bit; inverse and divide add one divide and one
// multiply per Euclid step. One request is in flight at a time: req.ready
// is high only when the sequencer is idle. A finished result is held in
// the output register until rsp.ready; the next request is taken the cycle
// after. Reset loads the default modulus set and empties the block; no
// clearing pass is needed.
`timescale 1ns / 1ps
`include "montgomery_modular_alu_defines.svh"

module montgomery_modular_alu #(
    parameter int MOD_BITS = mma_pkg::MOD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    mma_req_if.sink                       req,
    mma_rsp_if.source                     rsp,
    input  logic                          cfg_write,
    input  logic [mma_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mma_pkg::DATA_W-1:0]    cfg_data
);

    localparam int W = mma_pkg::DATA_W;

    logic [MOD_BITS-1:0] modulus_reg;
    logic [MOD_BITS-1:0] r2_reg;
    logic [W-1:0]        ninv_reg;

    mma_pkg::state_t state_reg, state_next;
    mma_pkg::state_t mm_ret_reg, mm_ret_next;
    mma_pkg::state_t tm_ret_reg, tm_ret_next;
    mma_pkg::state_t inv_ret_reg, inv_ret_next;

    logic [mma_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [W-1:0] opb_reg, opb_next;
    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] tm_bits_reg, tm_bits_next;
    logic [W-1:0] mm_x_reg, mm_x_next;
    logic [W-1:0] mm_y_reg, mm_y_next;
    logic [W-1:0] mm_h_reg, mm_h_next;
    logic [W-1:0] mm_l_reg, mm_l_next;
    logic [W-1:0] mm_q_reg, mm_q_next;
    logic [W-1:0] mm_res_reg, mm_res_next;
    logic [W-1:0] ex_reg, ex_next;
    logic [W-1:0] ey_reg, ey_next;
    logic [W-1:0] eu_u_reg, eu_u_next;
    logic [W-1:0] eu_v_reg, eu_v_next;
    logic [W-1:0] eu_t_reg, eu_t_next;
    logic [W-1:0] pw_e_reg, pw_e_next;
    logic         pw_neg_reg, pw_neg_next;
    logic [W-1:0] pw_res_reg, pw_res_next;
    logic [W-1:0] pw_base_reg, pw_base_next;
    logic [mma_pkg::RES_W-1:0] residue_reg, residue_next;
    logic         is_equal_reg, is_equal_next;

    logic         mul_start, div_start;
    logic [W-1:0] mul_a, mul_b, mul_hi, mul_lo;
    logic [W-1:0] div_n, div_d, div_q, div_r;
    mma_pkg::unit_stat_t mul_stat, div_stat;

    logic [W-1:0] mod64, two_mod, r2_64, ninv_neg;
    logic         tm_neg;
    logic [W-1:0] tm_mag, tm_t;
    logic [W-1:0] add_raw, add_val, sub_raw, sub_val, neg_raw, neg_val;
    logic [W-1:0] ca, cb, red_val, pw_mag, redc_val;
    logic [W:0]   low_sum;

    mma_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .hi    (mul_hi),
        .lo    (mul_lo),
        .stat  (mul_stat)
    );

    mma_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_n),
        .divisor   (div_d),
        .quotient  (div_q),
        .remainder (div_r),
        .stat      (div_stat)
    );

    assign mod64    = {{(W-MOD_BITS){1'b0}}, modulus_reg};
    assign r2_64    = {{(W-MOD_BITS){1'b0}}, r2_reg};
    assign two_mod  = {mod64[W-2:0], 1'b0};
    assign ninv_neg = ~ninv_reg + 1'b1;

    assign tm_neg = tm_bits_reg[W-1];
    assign tm_mag = tm_neg ? (~tm_bits_reg + 1'b1) : tm_bits_reg;
    assign tm_t   = tm_neg ? (mod64 - div_r) : (mod64 + div_r);

    assign add_raw = a_reg + mm_res_reg - two_mod;
    assign add_val = add_raw[W-1] ? (add_raw + two_mod) : add_raw;
    assign sub_raw = a_reg - mm_res_reg;
    assign sub_val = sub_raw[W-1] ? (sub_raw + two_mod) : sub_raw;
    assign neg_raw = mm_res_reg - a_reg;
    assign neg_val = neg_raw[W-1] ? (neg_raw + two_mod) : neg_raw;

    assign ca      = (a_reg >= mod64) ? (a_reg - mod64) : a_reg;
    assign cb      = (mm_res_reg >= mod64) ? (mm_res_reg - mod64) : mm_res_reg;
    assign red_val = cb;
    assign pw_mag  = opb_reg[W-1] ? (~opb_reg + 1'b1) : opb_reg;

    // high word of the reduction, carry taken from the low-word sum
    assign low_sum  = {1'b0, mm_l_reg} + {1'b0, mul_lo};
    assign redc_val = mm_h_reg + mul_hi + {{(W-1){1'b0}}, low_sum[W]};

    assign req.ready    = (state_reg == mma_pkg::ST_IDLE);
    assign rsp.valid    = (state_reg == mma_pkg::ST_OUT);
    assign rsp.residue  = residue_reg;
    assign rsp.is_equal = is_equal_reg;

    always_comb
    begin
        state_next    = state_reg;
        mm_ret_next   = mm_ret_reg;
        tm_ret_next   = tm_ret_reg;
        inv_ret_next  = inv_ret_reg;
        cmd_next      = cmd_reg;
        opb_next      = opb_reg;
        a_next        = a_reg;
        tm_bits_next  = tm_bits_reg;
        mm_x_next     = mm_x_reg;
        mm_y_next     = mm_y_reg;
        mm_h_next     = mm_h_reg;
        mm_l_next     = mm_l_reg;
        mm_q_next     = mm_q_reg;
        mm_res_next   = mm_res_reg;
        ex_next       = ex_reg;
        ey_next       = ey_reg;
        eu_u_next     = eu_u_reg;
        eu_v_next     = eu_v_reg;
        eu_t_next     = eu_t_reg;
        pw_e_next     = pw_e_reg;
        pw_neg_next   = pw_neg_reg;
        pw_res_next   = pw_res_reg;
        pw_base_next  = pw_base_reg;
        residue_next  = residue_reg;
        is_equal_next = is_equal_reg;
        mul_start     = 1'b0;
        mul_a         = mm_x_reg;
        mul_b         = mm_y_reg;
        div_start     = 1'b0;
        div_n         = tm_mag;
        div_d         = mod64;

        unique case (state_reg)
            mma_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next     = req.command;
                    opb_next     = $unsigned(req.operand_b);
                    tm_bits_next = $unsigned(req.operand_a);
                    tm_ret_next  = mma_pkg::ST_A_DONE;
                    if (mod64 == '0)
                    begin
                        residue_next  = '0;
                        is_equal_next = 1'b0;
                        state_next    = mma_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = mma_pkg::ST_TM_DIV;
                    end
                end
            end
            mma_pkg::ST_TM_DIV:
            begin
                div_start = 1'b1;
                if (div_stat.done)
                begin
                    mm_x_next   = tm_t;
                    mm_y_next   = r2_64;
                    mm_ret_next = tm_ret_reg;
                    state_next  = mma_pkg::ST_MM1;
                end
            end
            mma_pkg::ST_MM1:
            begin
                mul_start = 1'b1;
                if (mul_stat.done)
                begin
                    mm_h_next  = mul_hi;
                    mm_l_next  = mul_lo;
                    state_next = mma_pkg::ST_MM2;
                end
            end
            mma_pkg::ST_MM2:
            begin
                mul_start = 1'b1;
                mul_a     = mm_l_reg;
                mul_b     = ninv_neg;
                if (mul_stat.done)
                begin
                    mm_q_next  = mul_lo;
                    state_next = mma_pkg::ST_MM3;
                end
            end
            mma_pkg::ST_MM3:
            begin
                mul_start = 1'b1;
                mul_a     = mm_q_reg;
                mul_b     = mod64;
                if (mul_stat.done)
                begin
                    mm_res_next = redc_val;
                    state_next  = mm_ret_reg;
                end
            end
            mma_pkg::ST_A_DONE:
            begin
                a_next       = mm_res_reg;
                tm_bits_next = opb_reg;
                tm_ret_next  = mma_pkg::ST_B_DONE;
                state_next   = mma_pkg::ST_TM_DIV;
            end
            mma_pkg::ST_B_DONE:
            begin
                mm_y_next   = {{(W-1){1'b0}}, 1'b1};
                mm_ret_next = mma_pkg::ST_PL_FIN;
                state_next  = mma_pkg::ST_MM1;
                case (cmd_reg)
                    mma_pkg::CMD_ADD: mm_x_next = add_val;
                    mma_pkg::CMD_SUB: mm_x_next = sub_val;
                    mma_pkg::CMD_MUL:
                    begin
                        mm_x_next   = a_reg;
                        mm_y_next   = mm_res_reg;
                        mm_ret_next = mma_pkg::ST_R_MM;
                    end
                    mma_pkg::CMD_DIV:
                    begin
                        mm_x_next    = mm_res_reg;
                        mm_ret_next  = mma_pkg::ST_INV_P;
                        inv_ret_next = mma_pkg::ST_DIV_INV;
                    end
                    mma_pkg::CMD_POW:
                    begin
                        pw_neg_next  = opb_reg[W-1];
                        pw_e_next    = pw_mag;
                        pw_base_next = a_reg;
                        tm_bits_next = {{(W-1){1'b0}}, 1'b1};
                        tm_ret_next  = mma_pkg::ST_POW_INIT;
                        state_next   = mma_pkg::ST_TM_DIV;
                    end
                    mma_pkg::CMD_INV:
                    begin
                        mm_x_next    = a_reg;
                        mm_ret_next  = mma_pkg::ST_INV_P;
                        inv_ret_next = mma_pkg::ST_R_MM;
                    end
                    mma_pkg::CMD_NEG:
                    begin
                        tm_bits_next = '0;
                        tm_ret_next  = mma_pkg::ST_NEG_Z;
                        state_next   = mma_pkg::ST_TM_DIV;
                    end
                    default:
                    begin
                        residue_next  = '0;
                        is_equal_next = (ca == cb);
                        state_next    = mma_pkg::ST_OUT;
                    end
                endcase
            end
            mma_pkg::ST_R_MM:
            begin
                mm_x_next   = mm_res_reg;
                mm_y_next   = {{(W-1){1'b0}}, 1'b1};
                mm_ret_next = mma_pkg::ST_PL_FIN;
                state_next  = mma_pkg::ST_MM1;
            end
            mma_pkg::ST_PL_FIN:
            begin
                residue_next  = red_val[mma_pkg::RES_W-1:0];
                is_equal_next = 1'b0;
                state_next    = mma_pkg::ST_OUT;
            end
            mma_pkg::ST_DIV_INV:
            begin
                mm_x_next   = a_reg;
                mm_y_next   = mm_res_reg;
                mm_ret_next = mma_pkg::ST_R_MM;
                state_next  = mma_pkg::ST_MM1;
            end
            mma_pkg::ST_INV_P:
            begin
                ex_next    = red_val;
                state_next = mma_pkg::ST_INV_MOD;
            end
            mma_pkg::ST_INV_MOD:
            begin
                div_start = 1'b1;
                div_n     = ex_reg;
                if (div_stat.done)
                begin
                    ex_next    = div_r;
                    ey_next    = mod64;
                    eu_u_next  = {{(W-1){1'b0}}, 1'b1};
                    eu_v_next  = '0;
                    state_next = mma_pkg::ST_EU_LOOP;
                end
            end
            mma_pkg::ST_EU_LOOP:
            begin
                if (ey_reg == '0)
                begin
                    tm_bits_next = eu_u_reg;
                    tm_ret_next  = inv_ret_reg;
                    state_next   = mma_pkg::ST_TM_DIV;
                end
                else
                begin
                    state_next = mma_pkg::ST_EU_DIV;
                end
            end
            mma_pkg::ST_EU_DIV:
            begin
                div_start = 1'b1;
                div_n     = ex_reg;
                div_d     = ey_reg;
                if (div_stat.done)
                begin
                    eu_t_next  = div_q;
                    ex_next    = div_r;
                    state_next = mma_pkg::ST_EU_MUL;
                end
            end
            mma_pkg::ST_EU_MUL:
            begin
                mul_start = 1'b1;
                mul_a     = eu_v_reg;
                mul_b     = eu_t_reg;
                if (mul_stat.done)
                begin
                    // swap the pairs after the step
                    ex_next    = ey_reg;
                    ey_next    = ex_reg;
                    eu_u_next  = eu_v_reg;
                    eu_v_next  = eu_u_reg - mul_lo;
                    state_next = mma_pkg::ST_EU_LOOP;
                end
            end
            mma_pkg::ST_POW_INIT:
            begin
                pw_res_next = mm_res_reg;
                state_next  = mma_pkg::ST_POW_LOOP;
            end
            mma_pkg::ST_POW_LOOP:
            begin
                if (pw_e_reg == '0)
                begin
                    mm_x_next  = pw_res_reg;
                    mm_y_next  = {{(W-1){1'b0}}, 1'b1};
                    state_next = mma_pkg::ST_MM1;
                    if (pw_neg_reg)
                    begin
                        mm_ret_next  = mma_pkg::ST_INV_P;
                        inv_ret_next = mma_pkg::ST_R_MM;
                    end
                    else
                    begin
                        mm_ret_next = mma_pkg::ST_PL_FIN;
                    end
                end
                else if (pw_e_reg[0])
                begin
                    mm_x_next   = pw_res_reg;
                    mm_y_next   = pw_base_reg;
                    mm_ret_next = mma_pkg::ST_POW_RES;
                    state_next  = mma_pkg::ST_MM1;
                end
                else
                begin
                    state_next = mma_pkg::ST_POW_SQ;
                end
            end
            mma_pkg::ST_POW_RES:
            begin
                pw_res_next = mm_res_reg;
                state_next  = mma_pkg::ST_POW_SQ;
            end
            mma_pkg::ST_POW_SQ:
            begin
                mm_x_next   = pw_base_reg;
                mm_y_next   = pw_base_reg;
                mm_ret_next = mma_pkg::ST_POW_BASE;
                state_next  = mma_pkg::ST_MM1;
            end
            mma_pkg::ST_POW_BASE:
            begin
                pw_base_next = mm_res_reg;
                pw_e_next    = {1'b0, pw_e_reg[W-1:1]};
                state_next   = mma_pkg::ST_POW_LOOP;
            end
            mma_pkg::ST_NEG_Z:
            begin
                mm_x_next   = neg_val;
                mm_y_next   = {{(W-1){1'b0}}, 1'b1};
                mm_ret_next = mma_pkg::ST_PL_FIN;
                state_next  = mma_pkg::ST_MM1;
            end
            mma_pkg::ST_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = mma_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mma_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mma_pkg::ST_IDLE;
            mm_ret_reg  <= mma_pkg::ST_IDLE;
            tm_ret_reg  <= mma_pkg::ST_IDLE;
            inv_ret_reg <= mma_pkg::ST_IDLE;
        end
        else
        begin
            state_reg   <= state_next;
            mm_ret_reg  <= mm_ret_next;
            tm_ret_reg  <= tm_ret_next;
            inv_ret_reg <= inv_ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        opb_reg      <= opb_next;
        a_reg        <= a_next;
        tm_bits_reg  <= tm_bits_next;
        mm_x_reg     <= mm_x_next;
        mm_y_reg     <= mm_y_next;
        mm_h_reg     <= mm_h_next;
        mm_l_reg     <= mm_l_next;
        mm_q_reg     <= mm_q_next;
        mm_res_reg   <= mm_res_next;
        ex_reg       <= ex_next;
        ey_reg       <= ey_next;
        eu_u_reg     <= eu_u_next;
        eu_v_reg     <= eu_v_next;
        eu_t_reg     <= eu_t_next;
        pw_e_reg     <= pw_e_next;
        pw_neg_reg   <= pw_neg_next;
        pw_res_reg   <= pw_res_next;
        pw_base_reg  <= pw_base_next;
        residue_reg  <= residue_next;
        is_equal_reg <= is_equal_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= mma_pkg::MODULUS_RST[MOD_BITS-1:0];
            r2_reg      <= mma_pkg::R_SQUARED_RST[MOD_BITS-1:0];
            ninv_reg    <= mma_pkg::MOD_INV_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mma_pkg::REG_MODULUS:   modulus_reg <= cfg_data[MOD_BITS-1:0];
                mma_pkg::REG_R_SQUARED: r2_reg      <= cfg_data[MOD_BITS-1:0];
                mma_pkg::REG_MOD_INV:   ninv_reg    <= cfg_data;
                default:                ;
            endcase
        end
    end

    `MMA_ASSERT_IMP(a_units_exclusive, 1'b1, !(mul_stat.busy && div_stat.busy), "both busy")
    `MMA_ASSERT_IMP(a_out_units_idle, rsp.valid, !mul_stat.busy && !div_stat.busy, "unit busy")
    `MMA_ASSERT_IMP(a_eq_zero_res, rsp.valid && rsp.is_equal, rsp.residue == '0, "eq residue")
    `MMA_ASSERT_NXT(a_one_beat, rsp.valid && rsp.ready, !rsp.valid, "result beat repeated")

endmodule
